FILE: rtl/core/catu_pkg.sv
// ----------------------------------------------------------------------------
// catu_pkg: shared types and constants for the cell to terminal encoder
// Job record passed from the front (classifier) to the back (byte emitter).
// ----------------------------------------------------------------------------
`default_nettype none

package catu_pkg;

  localparam logic [7:0] ChEsc   = 8'h1B;
  localparam logic [7:0] ChLbr   = 8'h5B;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChM     = 8'h6D;

  // Three decimal digits; ndig gives how many are printed (1..3).
  typedef struct packed {
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
    logic [1:0] ndig;
  } dec3_t;

  typedef struct packed {
    logic       home;
    logic       sgr;
    logic       bold;
    logic       fg_en;
    dec3_t      fg;
    logic       bg_en;
    dec3_t      bg;
    logic [1:0] ulen;     // utf8 bytes minus one
    logic [31:0] ubytes;  // utf8 bytes, first in [31:24]
    logic       fend;
    logic       rend;
    dec3_t      row;
  } job_t;

  // Emitter phases, one-hot.
  typedef enum logic [9:0] {
    PhHome = 10'b0000000001,
    PhSgrH = 10'b0000000010,
    PhBold = 10'b0000000100,
    PhFg   = 10'b0000001000,
    PhBg   = 10'b0000010000,
    PhSgrM = 10'b0000100000,
    PhUtf  = 10'b0001000000,
    PhEnd  = 10'b0010000000,
    PhRow  = 10'b0100000000,
    PhRowT = 10'b1000000000
  } phase_e;

  // Decimal split of a value below 1000: each digit comes from parallel
  // compares against constants, then one subtract.
  function automatic dec3_t to_dec3(input logic [9:0] v);
    logic [9:0] r;
    logic [3:0] h;
    logic [3:0] t;
    dec3_t      o;
    h = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 10'(i * 100)) h = 4'(i);
    end
    r = v - 10'({6'd0, h} * 10'd100);
    t = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 10'(i * 10)) t = 4'(i);
    end
    r = r - 10'({6'd0, t} * 10'd10);
    o.d2 = h;
    o.d1 = t;
    o.d0 = r[3:0];
    o.ndig = (h != 4'd0) ? 2'd3 : ((t != 4'd0) ? 2'd2 : 2'd1);
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/catu_front.sv
// ----------------------------------------------------------------------------
// catu_front: accepts cells, tracks attribute and row state, builds jobs
// One cell per cycle when the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module catu_front #(
  parameter int MaxRows = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [8:0]      cfg_wdata_i,
  input  wire logic            valid_i,
  output logic                 stall_o,
  input  wire logic [20:0]     code_point_i,
  input  wire logic [8:0]      fg_color_i,
  input  wire logic [8:0]      bg_color_i,
  input  wire logic            bold_on_i,
  input  wire logic            first_of_frame_i,
  input  wire logic            end_of_row_i,
  input  wire logic            end_of_frame_i,
  output logic                 push_o,
  input  wire logic            full_i,
  output catu_pkg::job_t       job_o
);

  localparam logic [7:0] RowMax = 8'(MaxRows - 1);

  logic [8:0] dflt_q, fg_q, bg_q;
  logic       bold_q, known_q;
  logic [7:0] row_q;
  logic       acc;
  logic       known_eff, sgr;
  logic [7:0] row_eff;

  assign stall_o   = full_i;
  assign acc       = valid_i && !full_i;
  assign push_o    = acc;
  assign known_eff = known_q && !first_of_frame_i;
  assign row_eff   = first_of_frame_i ? 8'd0 : row_q;
  assign sgr       = !known_eff || fg_color_i != fg_q || bg_color_i != bg_q ||
                     bold_on_i != bold_q;

  always_comb begin
    job_o.home  = first_of_frame_i;
    job_o.sgr   = sgr;
    job_o.bold  = bold_on_i;
    job_o.fg_en = fg_color_i != dflt_q;
    job_o.fg    = catu_pkg::to_dec3({1'b0, fg_color_i});
    job_o.bg_en = bg_color_i != dflt_q;
    job_o.bg    = catu_pkg::to_dec3({1'b0, bg_color_i});
    job_o.fend  = end_of_frame_i;
    job_o.rend  = end_of_row_i;
    job_o.row   = catu_pkg::to_dec3({2'b00, row_eff} + 10'd2);
    if (code_point_i < 21'h80) begin
      job_o.ulen   = 2'd0;
      job_o.ubytes = {code_point_i[7:0], 24'd0};
    end else if (code_point_i < 21'h800) begin
      job_o.ulen   = 2'd1;
      job_o.ubytes = {8'hC0 | code_point_i[13:6], 2'b10, code_point_i[5:0], 16'd0};
    end else if (code_point_i < 21'h10000) begin
      job_o.ulen   = 2'd2;
      job_o.ubytes = {8'hE0 | code_point_i[19:12], 2'b10, code_point_i[11:6],
                      2'b10, code_point_i[5:0], 8'd0};
    end else begin
      job_o.ulen   = 2'd3;
      job_o.ubytes = {5'b11110, code_point_i[20:18], 2'b10, code_point_i[17:12],
                      2'b10, code_point_i[11:6], 2'b10, code_point_i[5:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q  <= 9'd511;
      fg_q    <= 9'd0;
      bg_q    <= 9'd0;
      bold_q  <= 1'b0;
      known_q <= 1'b0;
      row_q   <= 8'd0;
    end else begin
      if (cfg_we_i) dflt_q <= cfg_wdata_i;
      if (acc) begin
        if (sgr) begin
          fg_q   <= fg_color_i;
          bg_q   <= bg_color_i;
          bold_q <= bold_on_i;
        end
        if (end_of_frame_i) begin
          known_q <= 1'b0;
          row_q   <= 8'd0;
        end else begin
          known_q <= 1'b1;
          if (end_of_row_i && row_eff < RowMax) row_q <= row_eff + 8'd1;
          else                                  row_q <= row_eff;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/catu_queue.sv
// ----------------------------------------------------------------------------
// catu_queue: two-entry job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module catu_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire catu_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                nonempty_o,
  output catu_pkg::job_t      job_o
);

  catu_pkg::job_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign nonempty_o = cnt_q != 2'd0;
  assign job_o      = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/catu_back.sv
// ----------------------------------------------------------------------------
// catu_back: walks one job and emits its bytes into an output register
// ----------------------------------------------------------------------------
`default_nettype none

module catu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           nonempty_i,
  input  wire catu_pkg::job_t job_i,
  output logic                pop_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_run_o
);

  catu_pkg::phase_e ph_q, ph_d;
  logic [2:0] k_q, k_d;
  logic       busy_q, busy_d;
  logic       vld_q;
  logic [7:0] byte_q, b;
  logic       last_q, last;
  logic       emit, done;
  catu_pkg::phase_e start_ph;

  function automatic logic [7:0] dch(input catu_pkg::dec3_t d, input logic [1:0] i);
    logic [3:0] x;
    x = (i == 2'd0) ? d.d0 : ((i == 2'd1) ? d.d1 : d.d2);
    return catu_pkg::ChZero | {4'd0, x};
  endfunction

  // Decimal field ";ddd": k=0 is ';', then digits most significant first.
  function automatic logic [7:0] dfield(input catu_pkg::dec3_t d, input logic [2:0] k);
    if (k == 3'd0) return catu_pkg::ChSemi;
    return dch(d, 2'(d.ndig - k[1:0]));
  endfunction

  function automatic catu_pkg::phase_e after_sgrh(input catu_pkg::job_t j);
    if (j.bold)  return catu_pkg::PhBold;
    if (j.fg_en) return catu_pkg::PhFg;
    if (j.bg_en) return catu_pkg::PhBg;
    return catu_pkg::PhSgrM;
  endfunction

  assign start_ph = job_i.home ? catu_pkg::PhHome :
                    (job_i.sgr ? catu_pkg::PhSgrH : catu_pkg::PhUtf);

  assign emit = (busy_q || nonempty_i) && (!vld_q || !stall_i);

  always_comb begin
    catu_pkg::phase_e ph;
    logic [2:0] k;
    ph     = busy_q ? ph_q : start_ph;
    k      = busy_q ? k_q : 3'd0;
    ph_d   = ph;
    k_d    = k + 3'd1;
    b      = 8'd0;
    done   = 1'b0;
    unique case (ph)
      catu_pkg::PhHome: begin
        unique case (k)
          3'd0:    b = catu_pkg::ChEsc;
          3'd1:    b = catu_pkg::ChLbr;
          3'd2:    b = catu_pkg::ChOne;
          3'd3:    b = catu_pkg::ChSemi;
          3'd4:    b = catu_pkg::ChOne;
          default: b = catu_pkg::ChH;
        endcase
        if (k == 3'd5) begin
          ph_d = job_i.sgr ? catu_pkg::PhSgrH : catu_pkg::PhUtf;
          k_d  = 3'd0;
        end
      end
      catu_pkg::PhSgrH: begin
        b = (k == 3'd0) ? catu_pkg::ChEsc : ((k == 3'd1) ? catu_pkg::ChLbr : catu_pkg::ChZero);
        if (k == 3'd2) begin
          ph_d = after_sgrh(job_i);
          k_d  = 3'd0;
        end
      end
      catu_pkg::PhBold: begin
        b = (k == 3'd0) ? catu_pkg::ChSemi : catu_pkg::ChOne;
        if (k == 3'd1) begin
          ph_d = job_i.fg_en ? catu_pkg::PhFg :
                 (job_i.bg_en ? catu_pkg::PhBg : catu_pkg::PhSgrM);
          k_d  = 3'd0;
        end
      end
      catu_pkg::PhFg: begin
        b = dfield(job_i.fg, k);
        if (k[1:0] == job_i.fg.ndig) begin
          ph_d = job_i.bg_en ? catu_pkg::PhBg : catu_pkg::PhSgrM;
          k_d  = 3'd0;
        end
      end
      catu_pkg::PhBg: begin
        b = dfield(job_i.bg, k);
        if (k[1:0] == job_i.bg.ndig) begin
          ph_d = catu_pkg::PhSgrM;
          k_d  = 3'd0;
        end
      end
      catu_pkg::PhSgrM: begin
        b    = catu_pkg::ChM;
        ph_d = catu_pkg::PhUtf;
        k_d  = 3'd0;
      end
      catu_pkg::PhUtf: begin
        unique case (k[1:0])
          2'd0:    b = job_i.ubytes[31:24];
          2'd1:    b = job_i.ubytes[23:16];
          2'd2:    b = job_i.ubytes[15:8];
          default: b = job_i.ubytes[7:0];
        endcase
        if (k[1:0] == job_i.ulen) begin
          k_d = 3'd0;
          if (job_i.fend)      ph_d = catu_pkg::PhEnd;
          else if (job_i.rend) ph_d = catu_pkg::PhRow;
          else                 done = 1'b1;
        end
      end
      catu_pkg::PhEnd: begin
        unique case (k[1:0])
          2'd0:    b = catu_pkg::ChEsc;
          2'd1:    b = catu_pkg::ChLbr;
          2'd2:    b = catu_pkg::ChZero;
          default: b = catu_pkg::ChM;
        endcase
        if (k == 3'd3) done = 1'b1;
      end
      catu_pkg::PhRow: begin
        if (k == 3'd0)      b = catu_pkg::ChEsc;
        else if (k == 3'd1) b = catu_pkg::ChLbr;
        else                b = dch(job_i.row, 2'(job_i.row.ndig - 2'(k - 3'd1)));
        if (k == 3'(job_i.row.ndig + 2'd1) || (job_i.row.ndig == 2'd3 && k == 3'd4)) begin
          ph_d = catu_pkg::PhRowT;
          k_d  = 3'd0;
        end
      end
      catu_pkg::PhRowT: begin
        b = (k == 3'd0) ? catu_pkg::ChSemi : ((k == 3'd1) ? catu_pkg::ChOne : catu_pkg::ChH);
        if (k == 3'd2) done = 1'b1;
      end
      default: b = 8'd0;
    endcase
    last   = done;
    busy_d = !done;
  end

  assign pop_o         = emit && done;
  assign valid_o       = vld_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q <= b;
      last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= catu_pkg::PhUtf;
      k_q    <= 3'd0;
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      if (emit) begin
        ph_q   <= ph_d;
        k_q    <= k_d;
        busy_q <= busy_d;
        vld_q  <= 1'b1;
      end else if (!stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  a_last_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> nonempty_i) else $error("pop from empty queue");
  a_emit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> vld_q) else $error("emitted byte not held");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && stall_i) |=> vld_q && $stable(byte_q)) else $error("stalled byte lost");

endmodule

`default_nettype wire

FILE: rtl/core/cell_to_ansi_utf8_stream.sv
// ----------------------------------------------------------------------------
// cell_to_ansi_utf8_stream: screen cells to terminal byte stream
// Home, SGR set/reset, UTF-8 character and cursor-move sequences per cell.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  cell    | in        | cell_valid_i/cell_stall_o | code_point, colors, bold, flags
//  byte    | out       | byte_valid_o/byte_stall_i | out_byte, last_of_run
//  config  | in        | cfg_we_i                  | cfg_wdata_i (default color)
//
//  One output byte per cycle while byte_stall_i is low; a cell produces
//  1 to 32 bytes, set by the byte emitter walking the job.
//  The front classifies one cell per cycle into a two-entry job queue when not full.
//  Reset is asynchronous; no clearing pass.
//  The output register holds under stall; the front accepts until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_to_ansi_utf8_stream #(
  parameter int MaxRows = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  input  wire logic        cell_valid_i,
  output logic             cell_stall_o,
  input  wire logic [20:0] code_point_i,
  input  wire logic [8:0]  fg_color_i,
  input  wire logic [8:0]  bg_color_i,
  input  wire logic        bold_on_i,
  input  wire logic        first_of_frame_i,
  input  wire logic        end_of_row_i,
  input  wire logic        end_of_frame_i,
  output logic             byte_valid_o,
  input  wire logic        byte_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);

  catu_pkg::job_t fjob, bjob;
  logic push, full, pop, nonempty;

  catu_front #(.MaxRows(MaxRows)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .valid_i(cell_valid_i), .stall_o(cell_stall_o),
    .code_point_i, .fg_color_i, .bg_color_i, .bold_on_i,
    .first_of_frame_i, .end_of_row_i, .end_of_frame_i,
    .push_o(push), .full_i(full), .job_o(fjob)
  );

  catu_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(fjob), .full_o(full),
    .pop_i(pop), .nonempty_o(nonempty), .job_o(bjob)
  );

  catu_back u_back (
    .clk_i, .rst_ni, .nonempty_i(nonempty), .job_i(bjob), .pop_o(pop),
    .valid_o(byte_valid_o), .stall_i(byte_stall_i),
    .out_byte_o, .last_of_run_o
  );

endmodule

`default_nettype wire
